// ===== hdl/hsvls_pkg.sv =====
package hsvls_pkg;

  // Fixed field widths of the request and result.
  localparam int IdxW  = 4;
  localparam int ByteW = 8;

  // Hue prescale factor (192/256 gives three 64-step sections).
  localparam logic [ByteW-1:0] HUE_SCALE = 8'd192;
  // Largest byte value, used to invert the saturation.
  localparam logic [ByteW-1:0] MAX_BYTE  = 8'd255;
  // A fade divisor of 1.0 in 4.4 fixed point.
  localparam logic [ByteW-1:0] FADE_ONE  = 8'd16;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic             in_range;
    logic             fade_en;
    logic [ByteW-1:0] div;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } item_t;

  // One lane of the restoring divider: partial remainder, dividend bits
  // still to be shifted in, and the quotient built so far.
  typedef struct packed {
    logic [ByteW-1:0] rem;
    logic [ByteW-1:0] dvd;
    logic [ByteW-1:0] quo;
  } lane_t;

endpackage

// ===== hdl/hsvls_front.sv =====
module hsvls_front #(
  parameter int NUM_LEDS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsvls_pkg::IdxW-1:0]  led_index,
  input  logic [hsvls_pkg::ByteW-1:0] hue_in,
  input  logic [hsvls_pkg::ByteW-1:0] saturation,
  input  logic [hsvls_pkg::ByteW-1:0] brightness,
  input  logic                      fade_when_lower,
  input  logic [hsvls_pkg::ByteW-1:0] fade_divisor,
  output logic                      push,
  output hsvls_pkg::item_t          push_item,
  input  logic                      full
);
  import hsvls_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_BUSY = 1'b1;

  localparam logic [1:0] SECT_RG = 2'd0;
  localparam logic [1:0] SECT_GB = 2'd1;

  logic             state;
  logic [IdxW-1:0]  idx;
  logic             in_range;
  logic             fade_en;
  logic [ByteW-1:0] div;
  logic [ByteW-1:0] h;
  logic [ByteW-1:0] flr;
  logic [ByteW-1:0] val;

  logic             accept;
  logic [15:0]      hue_prod;
  logic [15:0]      flr_prod;
  logic [ByteW-1:0] amp;
  logic [5:0]       off;
  logic [13:0]      up_prod;
  logic [13:0]      down_prod;
  logic [ByteW-1:0] up;
  logic [ByteW-1:0] down;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  // First multiplier stage: prescaled hue and brightness floor.
  assign hue_prod = 16'(hue_in) * 16'(HUE_SCALE);
  assign flr_prod = 16'(brightness) * 16'(MAX_BYTE - saturation);

  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= led_index;
      in_range <= (int'(led_index) < NUM_LEDS);
      fade_en  <= fade_when_lower;
      div      <= (fade_divisor < FADE_ONE) ? FADE_ONE : fade_divisor;
      h        <= hue_prod[15:8];
      flr      <= flr_prod[15:8];
      val      <= brightness;
    end
  end

  // Second multiplier stage: rising and falling ramps within a section.
  assign amp       = val - flr;
  assign off       = h[5:0];
  assign up_prod   = 14'(off) * 14'(amp);
  assign down_prod = 14'(6'd63 - off) * 14'(amp);
  assign up        = up_prod[13:6] + flr;
  assign down      = down_prod[13:6] + flr;

  // Place the ramps on the channels according to the hue section.
  always_comb begin
    push_item          = '0;
    push_item.idx      = idx;
    push_item.in_range = in_range;
    push_item.fade_en  = fade_en;
    push_item.div      = div;
    unique case (h[7:6])
      SECT_RG: begin
        push_item.red   = down;
        push_item.green = up;
        push_item.blue  = flr;
      end
      SECT_GB: begin
        push_item.red   = flr;
        push_item.green = down;
        push_item.blue  = up;
      end
      default: begin
        push_item.red   = up;
        push_item.green = flr;
        push_item.blue  = down;
      end
    endcase
  end

  assign push = (state == F_BUSY) && !full;

  // Hold the request until the queue has room for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else if (accept) begin
      state <= F_BUSY;
    end else if (push) begin
      state <= F_IDLE;
    end
  end

endmodule

// ===== hdl/hsvls_queue.sv =====
module hsvls_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hsvls_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output hsvls_pkg::item_t head,
  output logic             head_valid
);
  import hsvls_pkg::*;

  localparam int Depth = 2;

  item_t       slots [Depth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'(Depth));
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  // Entry storage; only written on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/hsvls_back.sv =====
module hsvls_back #(
  parameter int NUM_LEDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hsvls_pkg::item_t            head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsvls_pkg::IdxW-1:0]  led_out,
  output logic [hsvls_pkg::ByteW-1:0] red_out,
  output logic [hsvls_pkg::ByteW-1:0] green_out,
  output logic [hsvls_pkg::ByteW-1:0] blue_out,
  output logic                        faded
);
  import hsvls_pkg::*;

  localparam int Depth = (NUM_LEDS < 16) ? NUM_LEDS : 16;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_DIV   = 2'd1;
  localparam logic [1:0] B_WRITE = 2'd2;

  logic [3*ByteW-1:0] store [Depth];

  logic [1:0]        state;
  logic [1:0]        step;
  item_t             item;
  logic              do_fade;
  lane_t             lane_r;
  lane_t             lane_g;
  lane_t             lane_b;

  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [ByteW-1:0]  st_r;
  logic [ByteW-1:0]  st_g;
  logic [ByteW-1:0]  st_b;
  logic              fade_go;
  logic              write_fire;
  logic [ByteW-1:0]  res_r;
  logic [ByteW-1:0]  res_g;
  logic [ByteW-1:0]  res_b;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l, logic [ByteW-1:0] d);
    logic [ByteW:0] trial;
    lane_t          n;
    trial = {l.rem, l.dvd[ByteW-1]};
    n.dvd = {l.dvd[ByteW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      n.rem = ByteW'(trial - {1'b0, d});
      n.quo = {l.quo[ByteW-2:0], 1'b1};
    end else begin
      n.rem = trial[ByteW-1:0];
      n.quo = {l.quo[ByteW-2:0], 1'b0};
    end
    return n;
  endfunction

  // Start a lane on channel*16: the top nibble is already below the divisor.
  function automatic lane_t lane_init(logic [ByteW-1:0] ch);
    lane_t l;
    l.rem = {4'd0, ch[7:4]};
    l.dvd = {ch[3:0], 4'd0};
    l.quo = '0;
    return l;
  endfunction

  // Read the stored colour for the queue head.
  assign rd_addr = head.in_range ? AddrW'(head.idx) : '0;
  assign {st_r, st_g, st_b} = store[rd_addr];

  assign pop     = (state == B_IDLE) && head_valid;
  assign fade_go = head.fade_en && head.in_range &&
                   (st_r > head.red) && (st_g > head.green) && (st_b > head.blue);

  assign write_fire = (state == B_WRITE) && (!out_valid || out_ready);

  assign res_r = do_fade ? lane_r.quo : item.red;
  assign res_g = do_fade ? lane_g.quo : item.green;
  assign res_b = do_fade ? lane_b.quo : item.blue;

  assign wr_addr = AddrW'(item.idx);

  // Sequencer: take a request, divide if fading, then write back and report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= 2'd0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            state <= fade_go ? B_DIV : B_WRITE;
            step  <= 2'd0;
          end
        end
        B_DIV: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= B_WRITE;
          end
        end
        B_WRITE: begin
          if (write_fire) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Working registers: the request and three divider lanes, two bits a cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      item    <= head;
      do_fade <= fade_go;
      lane_r  <= lane_init(st_r);
      lane_g  <= lane_init(st_g);
      lane_b  <= lane_init(st_b);
    end else if (state == B_DIV) begin
      lane_r <= div_step(div_step(lane_r, item.div), item.div);
      lane_g <= div_step(div_step(lane_g, item.div), item.div);
      lane_b <= div_step(div_step(lane_b, item.div), item.div);
    end
  end

  // Colour store, cleared to black at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        store[i] <= '0;
      end
    end else if (write_fire && item.in_range) begin
      store[wr_addr] <= {res_r, res_g, res_b};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_fire) begin
      led_out   <= item.idx;
      red_out   <= res_r;
      green_out <= res_g;
      blue_out  <= res_b;
      faded     <= do_fade;
    end
  end

endmodule

// ===== hdl/hsv_spectrum_led_color_store_unit.sv =====
// LED colour store with spectrum HSV to RGB conversion and fade-if-lower.
//
// Requests arrive on the in_valid/in_ready channel: an LED index, hue,
// saturation, brightness, a fade flag and a 4.4 fade divisor. Each request
// gives exactly one result on the out_valid/out_ready channel: the index and
// the colour now stored for that LED, with faded set if the stored colour was
// divided rather than overwritten. An index beyond the store leaves it alone
// and reports the computed colour.
// The front end converts the colour, registering it between its multipliers,
// and hands it to a two-entry queue; the back end reads the store, runs a
// three-lane divider at two quotient bits per cycle when fading, then writes
// back and loads the result.
// The back-end sequencer sets the rate: it takes the next request only once
// the last is written back, and the front end accepts no new request while
// it still holds one for the queue.
// Reset clears the whole store to black at once and empties the queue.
// When the receiver stalls, the result register holds; the queue then fills
// and in_ready falls, with no request lost.
module hsv_spectrum_led_color_store_unit #(
  parameter int NUM_LEDS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsvls_pkg::IdxW-1:0]  led_index,
  input  logic [hsvls_pkg::ByteW-1:0] hue_in,
  input  logic [hsvls_pkg::ByteW-1:0] saturation,
  input  logic [hsvls_pkg::ByteW-1:0] brightness,
  input  logic                        fade_when_lower,
  input  logic [hsvls_pkg::ByteW-1:0] fade_divisor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsvls_pkg::IdxW-1:0]  led_out,
  output logic [hsvls_pkg::ByteW-1:0] red_out,
  output logic [hsvls_pkg::ByteW-1:0] green_out,
  output logic [hsvls_pkg::ByteW-1:0] blue_out,
  output logic                        faded
);
  import hsvls_pkg::*;

  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  item_t head;
  logic  head_valid;

  // Colour conversion and classification.
  hsvls_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .led_index       (led_index),
    .hue_in          (hue_in),
    .saturation      (saturation),
    .brightness      (brightness),
    .fade_when_lower (fade_when_lower),
    .fade_divisor    (fade_divisor),
    .push            (push),
    .push_item       (push_item),
    .full            (full)
  );

  // Decoupling queue between the two halves.
  hsvls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Store update, fade division and result register.
  hsvls_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .led_out    (led_out),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .faded      (faded)
  );

endmodule
